/* rtl/ets_pkg.sv */
package ets_pkg;

  localparam int ETS_LENGTH_BITS = 16;
  localparam int ETS_QUEUE_DEPTH = 2;

  localparam int CP_BITS  = 21;
  localparam int OUT_BITS = 16;

  localparam logic [1:0] KIND_TILDE   = 2'd0;
  localparam logic [1:0] KIND_POSTFIX = 2'd1;
  localparam logic [1:0] KIND_TAGGED  = 2'd2;
  localparam logic [1:0] KIND_BOOL    = 2'd3;

  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_D = 8'h44;
  localparam logic [7:0] CH_N = 8'h4e;
  localparam logic [7:0] CH_O = 8'h4f;
  localparam logic [7:0] CH_R = 8'h52;
  localparam logic [7:0] CH_X = 8'h58;

  localparam logic [CP_BITS-1:0] CP_TAB_LO  = 21'h00009;
  localparam logic [CP_BITS-1:0] CP_TAB_HI  = 21'h0000d;
  localparam logic [CP_BITS-1:0] CP_SPACE   = 21'h00020;
  localparam logic [CP_BITS-1:0] CP_NBSP    = 21'h000a0;
  localparam logic [CP_BITS-1:0] CP_OGHAM   = 21'h01680;
  localparam logic [CP_BITS-1:0] CP_EN_LO   = 21'h02000;
  localparam logic [CP_BITS-1:0] CP_EN_HI   = 21'h0200b;
  localparam logic [CP_BITS-1:0] CP_LSEP    = 21'h02028;
  localparam logic [CP_BITS-1:0] CP_PSEP    = 21'h02029;
  localparam logic [CP_BITS-1:0] CP_NNBSP   = 21'h0202f;
  localparam logic [CP_BITS-1:0] CP_MMSP    = 21'h0205f;
  localparam logic [CP_BITS-1:0] CP_WJ      = 21'h02060;
  localparam logic [CP_BITS-1:0] CP_IDSP    = 21'h03000;
  localparam logic [CP_BITS-1:0] CP_BOM     = 21'h0feff;
  localparam logic [CP_BITS-1:0] CP_PIPE    = 21'h0007c;
  localparam logic [CP_BITS-1:0] CP_TILDE   = 21'h0007e;
  localparam logic [CP_BITS-1:0] CP_HYPHEN  = 21'h0002d;
  localparam logic [CP_BITS-1:0] CP_LBRACE  = 21'h0007b;
  localparam logic [CP_BITS-1:0] CP_UNDER   = 21'h0005f;
  localparam logic [CP_BITS-1:0] CP_UPPER_A = 21'h00041;
  localparam logic [CP_BITS-1:0] CP_UPPER_Z = 21'h0005a;
  localparam logic [CP_BITS-1:0] CP_LOWER_A = 21'h00061;
  localparam logic [CP_BITS-1:0] CP_LOWER_Z = 21'h0007a;
  localparam logic [CP_BITS-1:0] CP_DIGIT_0 = 21'h00030;
  localparam logic [CP_BITS-1:0] CP_DIGIT_9 = 21'h00039;

  typedef struct packed {
    logic       space;
    logic       letter;
    logic       name;
    logic       pipe;
    logic       tilde;
    logic       hyphen;
    logic       lbrace;
    logic [7:0] upper;
  } char_class_t;

  typedef struct packed {
    logic allow_tag;
    logic allow_post;
    logic allow_tilde;
    logic allow_bool;
  } allow_t;

  typedef struct packed {
    char_class_t cls;
    logic        start;
    allow_t      allow;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

/* rtl/ets_front.sv */
module ets_front
  import ets_pkg::*;
(
  input  logic [CP_BITS-1:0] code_point,
  input  logic               start_req,
  input  logic               allow_bool_op,
  input  logic               allow_prefix_tilde,
  input  logic               allow_postfix_name,
  input  logic               allow_tagged_record,
  output entry_t             entry
);

  logic c_upper;
  logic c_lower;
  logic c_digit;

  always_comb begin
    c_upper = (code_point >= CP_UPPER_A) && (code_point <= CP_UPPER_Z);
    c_lower = (code_point >= CP_LOWER_A) && (code_point <= CP_LOWER_Z);
    c_digit = (code_point >= CP_DIGIT_0) && (code_point <= CP_DIGIT_9);

    entry.cls.space = ((code_point >= CP_TAB_LO) && (code_point <= CP_TAB_HI)) ||
                      (code_point == CP_SPACE) || (code_point == CP_NBSP) ||
                      (code_point == CP_OGHAM) ||
                      ((code_point >= CP_EN_LO) && (code_point <= CP_EN_HI)) ||
                      (code_point == CP_LSEP) || (code_point == CP_PSEP) ||
                      (code_point == CP_NNBSP) || (code_point == CP_MMSP) ||
                      (code_point == CP_WJ) || (code_point == CP_IDSP) ||
                      (code_point == CP_BOM);
    entry.cls.letter = c_upper || c_lower;
    entry.cls.hyphen = (code_point == CP_HYPHEN);
    entry.cls.name   = c_upper || c_lower || c_digit || (code_point == CP_UNDER) ||
                       entry.cls.hyphen;
    entry.cls.pipe   = (code_point == CP_PIPE);
    entry.cls.tilde  = (code_point == CP_TILDE);
    entry.cls.lbrace = (code_point == CP_LBRACE);
    // fold to upper case by clearing bit 5
    entry.cls.upper  = {code_point[7:6], 1'b0, code_point[4:0]};

    entry.start            = start_req;
    entry.allow.allow_bool  = allow_bool_op;
    entry.allow.allow_tilde = allow_prefix_tilde;
    entry.allow.allow_post  = allow_postfix_name;
    entry.allow.allow_tag   = allow_tagged_record;
  end

endmodule

/* rtl/ets_queue.sv */
module ets_queue
  import ets_pkg::*;
#(
  parameter int DEPTH = ETS_QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  entry_t  wr_entry,
  input  logic    pop,
  output entry_t  rd_entry,
  output q_stat_t stat
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

  entry_t              mem_r [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  assign rd_entry   = mem_r[rd_ptr_r];
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == FULL_CNT);

endmodule

/* rtl/ets_back.sv */
module ets_back
  import ets_pkg::*;
#(
  parameter int LENGTH_BITS = ETS_LENGTH_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  entry_t              q_entry,
  output logic                pop,
  input  logic                out_stall,
  output logic                out_valid,
  output logic                out_accepted,
  output logic [1:0]          out_token_kind,
  output logic [OUT_BITS-1:0] out_token_length,
  output logic [OUT_BITS-1:0] out_skipped_count
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_SKIP   = 3'd1;
  localparam logic [2:0] PH_BOOL   = 3'd2;
  localparam logic [2:0] PH_TILDE  = 3'd3;
  localparam logic [2:0] PH_NAME   = 3'd4;
  localparam logic [2:0] PH_HYPHEN = 3'd5;

  localparam logic [2:0] MAX_LETTERS = 3'd4;
  localparam logic [LENGTH_BITS-1:0] CNT_ONE = LENGTH_BITS'(1);

  logic [2:0]             phase_r, phase_nxt;
  allow_t                 allow_r, allow_nxt;
  logic [7:0]             letters_r [4];
  logic [2:0]             lcount_r, lcount_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic [LENGTH_BITS-1:0] skip_r, skip_nxt;

  logic                   out_valid_r;
  logic                   acc_r;
  logic [1:0]             kind_r;
  logic [LENGTH_BITS-1:0] olen_r;
  logic [LENGTH_BITS-1:0] oskip_r;

  logic [2:0]             ph_e;
  allow_t                 af_e;
  logic [2:0]             lc_e;
  logic [LENGTH_BITS-1:0] len_e;
  logic [LENGTH_BITS-1:0] skip_e;
  logic [LENGTH_BITS-1:0] len_inc;
  logic [LENGTH_BITS-1:0] skip_inc;
  logic                   emit;
  logic                   emit_acc;
  logic [1:0]             emit_kind;
  logic                   wr_letter;
  logic                   op_ok;
  char_class_t            c;

  function automatic logic [LENGTH_BITS-1:0] sat_inc(input logic [LENGTH_BITS-1:0] v);
    sat_inc = (v == '1) ? v : v + 1'b1;
  endfunction

  assign pop = q_valid && (!out_valid_r || !out_stall);
  assign c   = q_entry.cls;

  always_comb begin
    op_ok = ((lcount_r == 3'd2) && (letters_r[0] == CH_O) && (letters_r[1] == CH_R)) ||
            ((lcount_r == 3'd3) && (letters_r[0] == CH_A) && (letters_r[1] == CH_N) &&
             (letters_r[2] == CH_D)) ||
            ((lcount_r == 3'd3) && (letters_r[0] == CH_X) && (letters_r[1] == CH_O) &&
             (letters_r[2] == CH_R)) ||
            ((lcount_r == 3'd3) && (letters_r[0] == CH_N) && (letters_r[1] == CH_O) &&
             (letters_r[2] == CH_R)) ||
            ((lcount_r == MAX_LETTERS) && (letters_r[0] == CH_N) &&
             (letters_r[1] == CH_A) && (letters_r[2] == CH_N) && (letters_r[3] == CH_D)) ||
            ((lcount_r == MAX_LETTERS) && (letters_r[0] == CH_N) &&
             (letters_r[1] == CH_X) && (letters_r[2] == CH_O) && (letters_r[3] == CH_R));
  end

  always_comb begin
    ph_e     = q_entry.start ? PH_SKIP : phase_r;
    af_e     = q_entry.start ? q_entry.allow : allow_r;
    lc_e     = q_entry.start ? 3'd0 : lcount_r;
    len_e    = q_entry.start ? '0 : len_r;
    skip_e   = q_entry.start ? '0 : skip_r;
    len_inc  = sat_inc(len_e);
    skip_inc = sat_inc(skip_e);

    phase_nxt  = ph_e;
    allow_nxt  = af_e;
    lcount_nxt = lc_e;
    len_nxt    = len_e;
    skip_nxt   = skip_e;
    emit       = 1'b0;
    emit_acc   = 1'b0;
    emit_kind  = KIND_TILDE;
    wr_letter  = 1'b0;

    case (ph_e)
      PH_SKIP: begin
        if (c.space) begin
          skip_nxt = skip_inc;
        end else if (af_e.allow_bool && c.pipe) begin
          len_nxt    = CNT_ONE;
          lcount_nxt = 3'd0;
          phase_nxt  = PH_BOOL;
        end else if (af_e.allow_tilde && c.tilde) begin
          len_nxt   = CNT_ONE;
          phase_nxt = PH_TILDE;
        end else if ((af_e.allow_post || af_e.allow_tag) && c.letter) begin
          len_nxt   = CNT_ONE;
          phase_nxt = PH_NAME;
        end else begin
          emit = 1'b1;
        end
      end
      PH_BOOL: begin
        if (c.letter) begin
          if (lc_e >= MAX_LETTERS) begin
            emit = 1'b1;
          end else begin
            wr_letter  = 1'b1;
            lcount_nxt = lc_e + 1'b1;
            len_nxt    = len_inc;
          end
        end else if (!c.name && op_ok) begin
          emit      = 1'b1;
          emit_acc  = 1'b1;
          emit_kind = KIND_BOOL;
        end else begin
          emit = 1'b1;
        end
      end
      PH_TILDE: begin
        emit     = 1'b1;
        emit_acc = c.letter;
      end
      PH_NAME: begin
        if (c.letter) begin
          len_nxt = len_inc;
        end else if (c.hyphen) begin
          len_nxt   = len_inc;
          phase_nxt = PH_HYPHEN;
        end else if (af_e.allow_post && c.tilde) begin
          emit      = 1'b1;
          emit_acc  = 1'b1;
          emit_kind = KIND_POSTFIX;
        end else if (af_e.allow_tag && c.lbrace) begin
          emit      = 1'b1;
          emit_acc  = 1'b1;
          emit_kind = KIND_TAGGED;
        end else begin
          emit = 1'b1;
        end
      end
      PH_HYPHEN: begin
        if (c.letter) begin
          len_nxt   = len_inc;
          phase_nxt = PH_NAME;
        end else begin
          emit = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase

    if (emit) begin
      phase_nxt = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      allow_r     <= '0;
      lcount_r    <= '0;
      len_r       <= '0;
      skip_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        phase_r  <= phase_nxt;
        allow_r  <= allow_nxt;
        lcount_r <= lcount_nxt;
        len_r    <= len_nxt;
        skip_r   <= skip_nxt;
      end
      if (pop && emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && wr_letter) begin
      letters_r[lc_e[1:0]] <= c.upper;
    end
    if (pop && emit) begin
      acc_r   <= emit_acc;
      kind_r  <= emit_acc ? emit_kind : KIND_TILDE;
      olen_r  <= emit_acc ? len_e : '0;
      oskip_r <= skip_e;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_accepted      = acc_r;
  assign out_token_kind    = kind_r;
  assign out_token_length  = OUT_BITS'(olen_r);
  assign out_skipped_count = OUT_BITS'(oskip_r);

endmodule

/* rtl/expression_token_scanner_unit.sv */
// expression token scanner
// input channel: one code point per request (in_valid / in_stall). a request
// with in_start_req high opens a scan attempt and samples the four allow flags;
// code point zero marks end of input.
// result channel: one request per decided attempt (out_valid / out_stall)
// carrying accepted, token kind, token length and skipped whitespace count.
// a rejected result has kind and length zero.
// throughput: one code point per cycle unless out_stall holds a result, whatever
// the token pattern; every code point gets the same fixed amount of work.
// a code point that decides an attempt is written into the queue, and its result
// is loaded into the result register when the state machine reads it out.
// the classifier writes into a small queue; the scan state machine drains it
// into a single result register. when out_stall is high while a result waits,
// the result holds and the state machine pauses; the queue keeps taking code
// points until full, and only then is in_stall raised.
// reset (rst_n low, synchronous) empties the queue, drops any attempt in
// progress and any result not yet taken.
module expression_token_scanner_unit
  import ets_pkg::*;
#(
  parameter int LENGTH_BITS = ETS_LENGTH_BITS,
  parameter int QUEUE_DEPTH = ETS_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CP_BITS-1:0]  in_code_point,
  input  logic                in_start_req,
  input  logic                in_allow_bool_op,
  input  logic                in_allow_prefix_tilde,
  input  logic                in_allow_postfix_name,
  input  logic                in_allow_tagged_record,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_accepted,
  output logic [1:0]          out_token_kind,
  output logic [OUT_BITS-1:0] out_token_length,
  output logic [OUT_BITS-1:0] out_skipped_count
);

  entry_t  fr_entry;
  entry_t  q_entry;
  q_stat_t q_stat;
  logic    push;
  logic    pop;

  ets_front u_front (
    .code_point          (in_code_point),
    .start_req           (in_start_req),
    .allow_bool_op       (in_allow_bool_op),
    .allow_prefix_tilde  (in_allow_prefix_tilde),
    .allow_postfix_name  (in_allow_postfix_name),
    .allow_tagged_record (in_allow_tagged_record),
    .entry               (fr_entry)
  );

  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  ets_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (fr_entry),
    .pop      (pop),
    .rd_entry (q_entry),
    .stat     (q_stat)
  );

  ets_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (!q_stat.empty),
    .q_entry           (q_entry),
    .pop               (pop),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_accepted      (out_accepted),
    .out_token_kind    (out_token_kind),
    .out_token_length  (out_token_length),
    .out_skipped_count (out_skipped_count)
  );

  // result register only reloads once the waiting result has gone
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> !pop)
    else $error("scan advanced while a result was held");

  // a queue entry is never read before it is written
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("queue popped while empty");

  a_reject_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |-> out_token_kind == KIND_TILDE && out_token_length == '0)
    else $error("rejected result carries token data");

  a_bool_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted && out_token_kind == KIND_BOOL |->
      out_token_length >= OUT_BITS'(3) && out_token_length <= OUT_BITS'(5))
    else $error("boolean operator of impossible length");

endmodule

/* dv/token_scoreboard_pkg.sv */
package token_scoreboard_pkg;
  import ets_pkg::*;

  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_SKIP,
    SCAN_BOOL,
    SCAN_TILDE,
    SCAN_NAME,
    SCAN_HYPHEN
  } scan_phase_e;

  typedef struct packed {
    logic                accepted;
    logic [1:0]          kind;
    logic [OUT_BITS-1:0] length;
    logic [OUT_BITS-1:0] skipped;
  } scan_result_t;

  class token_scoreboard;
    scan_result_t        pending_results[$];
    scan_phase_e         phase;
    allow_t              flags;
    logic [7:0]          op_letters[4];
    int                  letter_count;
    logic [OUT_BITS-1:0] length_count;
    logic [OUT_BITS-1:0] skip_count;
    int                  errors;
    int                  results_seen;
    int                  accepts_seen;

    function new();
      phase        = SCAN_IDLE;
      flags        = '0;
      letter_count = 0;
      length_count = '0;
      skip_count   = '0;
      errors       = 0;
      results_seen = 0;
      accepts_seen = 0;
    endfunction

    static function logic [OUT_BITS-1:0] sat_inc(logic [OUT_BITS-1:0] v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    static function bit alpha_cp(logic [CP_BITS-1:0] c);
      return (c >= CP_UPPER_A && c <= CP_UPPER_Z) || (c >= CP_LOWER_A && c <= CP_LOWER_Z);
    endfunction

    static function bit is_name_char(logic [CP_BITS-1:0] c);
      return alpha_cp(c) || (c >= CP_DIGIT_0 && c <= CP_DIGIT_9) || c == CP_UNDER ||
             c == CP_HYPHEN;
    endfunction

    static function bit blank_cp(logic [CP_BITS-1:0] c);
      return (c >= CP_TAB_LO && c <= CP_TAB_HI) || c == CP_SPACE || c == CP_NBSP ||
             c == CP_OGHAM || (c >= CP_EN_LO && c <= CP_EN_HI) || c == CP_LSEP ||
             c == CP_PSEP || c == CP_NNBSP || c == CP_MMSP || c == CP_WJ ||
             c == CP_IDSP || c == CP_BOM;
    endfunction

    function bit op_known();
      logic [23:0] w3;
      logic [31:0] w4;
      w3 = {op_letters[0], op_letters[1], op_letters[2]};
      w4 = {op_letters[0], op_letters[1], op_letters[2], op_letters[3]};
      case (letter_count)
        2: return {op_letters[0], op_letters[1]} == {CH_O, CH_R};
        3: return w3 == {CH_A, CH_N, CH_D} || w3 == {CH_X, CH_O, CH_R} ||
                  w3 == {CH_N, CH_O, CH_R};
        4: return w4 == {CH_N, CH_A, CH_N, CH_D} || w4 == {CH_N, CH_X, CH_O, CH_R};
        default: return 1'b0;
      endcase
    endfunction

    function void decide(logic acc, logic [1:0] kind);
      scan_result_t r;
      r.accepted = acc;
      r.kind     = acc ? kind : KIND_TILDE;
      r.length   = acc ? length_count : '0;
      r.skipped  = skip_count;
      pending_results.push_back(r);
      phase = SCAN_IDLE;
    endfunction

    function bit attempt_open();
      return phase != SCAN_IDLE;
    endfunction

    function void note_request(logic [CP_BITS-1:0] c, logic start, allow_t fl);
      if (start) begin
        flags        = fl;
        phase        = SCAN_SKIP;
        letter_count = 0;
        length_count = '0;
        skip_count   = '0;
      end
      case (phase)
        SCAN_SKIP: begin
          if (blank_cp(c)) begin
            skip_count = sat_inc(skip_count);
          end else if (flags.allow_bool && c == CP_PIPE) begin
            length_count = OUT_BITS'(1);
            letter_count = 0;
            phase        = SCAN_BOOL;
          end else if (flags.allow_tilde && c == CP_TILDE) begin
            length_count = OUT_BITS'(1);
            phase        = SCAN_TILDE;
          end else if ((flags.allow_post || flags.allow_tag) && alpha_cp(c)) begin
            length_count = OUT_BITS'(1);
            phase        = SCAN_NAME;
          end else begin
            decide(1'b0, KIND_TILDE);
          end
        end
        SCAN_BOOL: begin
          if (alpha_cp(c)) begin
            if (letter_count >= 4) begin
              decide(1'b0, KIND_TILDE);
            end else begin
              op_letters[letter_count] = (c >= CP_LOWER_A) ? c[7:0] - 8'd32 : c[7:0];
              letter_count++;
              length_count = sat_inc(length_count);
            end
          end else if (is_name_char(c) || !op_known()) begin
            decide(1'b0, KIND_TILDE);
          end else begin
            decide(1'b1, KIND_BOOL);
          end
        end
        SCAN_TILDE: decide(alpha_cp(c), KIND_TILDE);
        SCAN_NAME: begin
          if (alpha_cp(c)) begin
            length_count = sat_inc(length_count);
          end else if (c == CP_HYPHEN) begin
            length_count = sat_inc(length_count);
            phase        = SCAN_HYPHEN;
          end else if (flags.allow_post && c == CP_TILDE) begin
            decide(1'b1, KIND_POSTFIX);
          end else if (flags.allow_tag && c == CP_LBRACE) begin
            decide(1'b1, KIND_TAGGED);
          end else begin
            decide(1'b0, KIND_TILDE);
          end
        end
        SCAN_HYPHEN: begin
          if (alpha_cp(c)) begin
            length_count = sat_inc(length_count);
            phase        = SCAN_NAME;
          end else begin
            decide(1'b0, KIND_TILDE);
          end
        end
        default: phase = SCAN_IDLE;
      endcase
    endfunction

    function void cmp_field(longint unsigned now, string fname, logic [OUT_BITS-1:0] want,
                            logic [OUT_BITS-1:0] got);
      if (want !== got) begin
        $display("%0t ns: %s expected %0h actual %0h", now, fname, want, got);
        errors++;
      end
    endfunction

    function void check_result(longint unsigned now, logic acc, logic [1:0] kind,
                               logic [OUT_BITS-1:0] len, logic [OUT_BITS-1:0] skip);
      scan_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result expected none actual acc=%0h kind=%0h len=%0h skip=%0h",
                 now, acc, kind, len, skip);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      results_seen++;
      if (acc === 1'b1) accepts_seen++;
      cmp_field(now, "accepted", OUT_BITS'(want.accepted), OUT_BITS'(acc));
      cmp_field(now, "token_kind", OUT_BITS'(want.kind), OUT_BITS'(kind));
      cmp_field(now, "token_length", want.length, len);
      cmp_field(now, "skipped_count", want.skipped, skip);
    endfunction
  endclass

endpackage

/* dv/tb_expression_token_scanner_unit.sv */
module tb_expression_token_scanner_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ets_pkg::*;
  import token_scoreboard_pkg::*;

  localparam allow_t AL_BOOL  = 4'b0001;
  localparam allow_t AL_TILDE = 4'b0010;
  localparam allow_t AL_POST  = 4'b0100;
  localparam allow_t AL_TAG   = 4'b1000;
  localparam allow_t AL_ALL   = 4'b1111;
  localparam int RANDOM_ITEMS = 1050;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [CP_BITS-1:0]  in_code_point = '0;
  logic                in_start_req = 1'b0;
  logic                in_allow_bool_op = 1'b0;
  logic                in_allow_prefix_tilde = 1'b0;
  logic                in_allow_postfix_name = 1'b0;
  logic                in_allow_tagged_record = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_accepted;
  logic [1:0]          out_token_kind;
  logic [OUT_BITS-1:0] out_token_length;
  logic [OUT_BITS-1:0] out_skipped_count;

  token_scoreboard sb;
  int idle_pct = 0;
  int stall_pct = 0;
  int scan_items = 0;

  string op_words[14] = '{"OR", "AND", "XOR", "NOR", "NAND", "NXOR", "NO", "AN", "XO", "A",
                          "NANDX", "ORR", "NXORA", ""};
  logic [CP_BITS-1:0] near_spaces[8] = '{21'h8, 21'he, 21'h1f, 21'h200c, 21'h2027,
                                         21'h202a, 21'h2061, 21'hfefe};

  expression_token_scanner_unit u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_code_point         (in_code_point),
    .in_start_req          (in_start_req),
    .in_allow_bool_op      (in_allow_bool_op),
    .in_allow_prefix_tilde (in_allow_prefix_tilde),
    .in_allow_postfix_name (in_allow_postfix_name),
    .in_allow_tagged_record(in_allow_tagged_record),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_accepted          (out_accepted),
    .out_token_kind        (out_token_kind),
    .out_token_length      (out_token_length),
    .out_skipped_count     (out_skipped_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result($time, out_accepted, out_token_kind, out_token_length, out_skipped_count);
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_req(logic [CP_BITS-1:0] cp, logic start, allow_t fl);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid               <= 1'b1;
    in_code_point          <= cp;
    in_start_req           <= start;
    in_allow_bool_op       <= fl.allow_bool;
    in_allow_prefix_tilde  <= fl.allow_tilde;
    in_allow_postfix_name  <= fl.allow_post;
    in_allow_tagged_record <= fl.allow_tag;
    do @(posedge clk); while (in_stall);
    if (start || sb.attempt_open()) scan_items++;
    sb.note_request(cp, start, fl);
    @(negedge clk);
  endtask

  task automatic send_text(string s, allow_t fl);
    for (int i = 0; i < s.len(); i++) begin
      send_req({13'd0, 8'(s[i])}, i == 0, fl);
    end
  endtask

  function automatic logic [CP_BITS-1:0] rand_letter();
    logic [CP_BITS-1:0] c;
    c = CP_UPPER_A + CP_BITS'($urandom_range(25));
    return $urandom_range(1) ? c + 21'd32 : c;
  endfunction

  function automatic logic [CP_BITS-1:0] rand_space();
    case ($urandom_range(9))
      0: return CP_TAB_LO + CP_BITS'($urandom_range(4));
      1: return CP_SPACE;
      2: return CP_NBSP;
      3: return CP_OGHAM;
      4: return CP_EN_LO + CP_BITS'($urandom_range(11));
      5: return $urandom_range(1) ? CP_LSEP : CP_PSEP;
      6: return CP_NNBSP;
      7: return $urandom_range(1) ? CP_MMSP : CP_WJ;
      8: return CP_IDSP;
      default: return CP_BOM;
    endcase
  endfunction

  function automatic logic [CP_BITS-1:0] rand_term();
    case ($urandom_range(12))
      0: return '0;
      1: return rand_space();
      2: return 21'h28;
      3: return CP_DIGIT_0 + CP_BITS'($urandom_range(9));
      4: return CP_UNDER;
      5: return CP_HYPHEN;
      6: return rand_letter();
      7: return CP_TILDE;
      8: return CP_LBRACE;
      9: return CP_BITS'($urandom_range(21'h1fffff));
      10: return CP_BITS'($urandom_range(21'h10ffff, 21'h80));
      11: return CP_PIPE;
      default: return near_spaces[$urandom_range(7)];
    endcase
  endfunction

  task automatic rand_attempt();
    logic [CP_BITS-1:0] seq[$];
    allow_t fl;
    string word;
    int form;
    int runs;
    fl   = allow_t'(4'($urandom_range(15)));
    form = $urandom_range(9);
    if ($urandom_range(2) == 0) begin
      repeat ($urandom_range(4, 1)) seq.push_back(rand_space());
    end
    case (form)
      0, 1, 2: begin
        if ($urandom_range(9) < 8) fl.allow_bool = 1'b1;
        seq.push_back(CP_PIPE);
        word = op_words[$urandom_range(13)];
        for (int k = 0; k < word.len(); k++) begin
          seq.push_back({13'd0, 8'(word[k])} + ($urandom_range(1) ? 21'd32 : 21'd0));
        end
      end
      3, 4: begin
        if ($urandom_range(9) < 8) fl.allow_tilde = 1'b1;
        seq.push_back(CP_TILDE);
        seq.push_back($urandom_range(3) ? rand_letter() : rand_term());
      end
      5, 6, 7: begin
        if ($urandom_range(9) < 8) begin
          if ($urandom_range(1)) fl.allow_post = 1'b1;
          else fl.allow_tag = 1'b1;
        end
        runs = $urandom_range(3, 1);
        for (int r = 0; r < runs; r++) begin
          repeat ($urandom_range(4, 1)) seq.push_back(rand_letter());
          if (r < runs - 1) begin
            seq.push_back(CP_HYPHEN);
            if ($urandom_range(11) == 0) seq.push_back(CP_HYPHEN);
          end
        end
        if ($urandom_range(11) == 0) seq.push_back(CP_HYPHEN);
        case ($urandom_range(4))
          0, 1: seq.push_back(CP_TILDE);
          2, 3: seq.push_back(CP_LBRACE);
          default: seq.push_back(rand_term());
        endcase
      end
      8: seq.push_back(rand_term());
      default: seq.push_back(CP_BITS'($urandom_range(21'h1fffff)));
    endcase
    if ($urandom_range(9) != 0) seq.push_back(rand_term());
    foreach (seq[k]) begin
      send_req(seq[k], k == 0, (k == 0) ? fl : allow_t'(4'($urandom_range(15))));
    end
    if ($urandom_range(7) == 0) send_req(CP_BITS'($urandom_range(21'h1fffff)), 1'b0, AL_ALL);
  endtask

  initial begin
    #8ms;
    $display("timeout: results still pending");
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int wait_cycles;
    sb = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ignored while idle
    send_req(CP_LOWER_A, 1'b0, AL_ALL);
    send_text("|or ", AL_BOOL);
    send_text(" \t|NaNd", AL_BOOL);
    send_req('0, 1'b0, AL_BOOL);
    send_text("|NXOR(", AL_ALL);
    send_text("|xor_", AL_BOOL);
    send_text("|nandx", AL_BOOL);
    send_text("|an ", AL_BOOL);
    send_text("|or", AL_TILDE);
    send_text("~a", AL_TILDE);
    send_text("~1", AL_TILDE);
    send_text("ab-cd~", AL_POST);
    send_text("Ab{", AL_TAG);
    send_text("ab~", AL_TAG);
    send_text("ab--x", AL_POST);
    send_text("a-{", AL_TAG);
    // restart while an attempt is open
    send_text("|o", AL_BOOL);
    send_text("~z", AL_TILDE);
    send_req('0, 1'b1, AL_ALL);
    send_req(21'h1fffff, 1'b1, AL_ALL);
    send_req(21'h110000, 1'b1, AL_ALL);
    send_req(CP_BOM, 1'b1, AL_ALL);
    send_req(CP_IDSP, 1'b0, 4'b0000);
    send_req(21'h3a, 1'b0, 4'b0000);

    scan_items = 0;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 72; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 72; end
        default: begin idle_pct = 36; stall_pct = 36; end
      endcase
      while (scan_items < (ph + 1) * RANDOM_ITEMS / 4) rand_attempt();
    end
    idle_pct = 0;
    in_valid <= 1'b0;

    wait_cycles = 0;
    while (sb.pending_results.size() != 0 && wait_cycles < 5000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (20) @(posedge clk);
    if (sb.pending_results.size() != 0) begin
      $display("%0t ns: %0d results expected but never seen", $time,
               sb.pending_results.size());
      sb.errors++;
    end

    $display("scanned %0d code points in attempts; %0d results checked, %0d of them accepted",
             scan_items, sb.results_seen, sb.accepts_seen);
    $display("covered operators, tildes, names, whitespace, restarts and four idle mixes");
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/ets_pkg.sv
rtl/ets_front.sv
rtl/ets_queue.sv
rtl/ets_back.sv
rtl/expression_token_scanner_unit.sv
dv/token_scoreboard_pkg.sv
dv/tb_expression_token_scanner_unit.sv
